FILE: src/sla_pkg.sv
// Shared types and constants for the sparse Laplacian assembler.
package sla_pkg;

  localparam int MAX_COLUMNS = 65536;
  localparam int MAX_SLOTS   = 1048576;

  localparam int COL_W    = 16;
  localparam int ROW_W    = 16;
  localparam int SLOT_W   = 20;
  localparam int DIST_W   = 32;
  localparam int VALUE_W  = 48;
  localparam int WINDOW_W = 16;
  localparam int FRAC_W   = 16;

  // Quotient of 2^32 / d needs one bit more than the distance.
  localparam int QUOT_W    = DIST_W + 1;
  localparam int DIV_STEPS = QUOT_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam int S_TDATA_W = ((ROW_W + DIST_W + 7) / 8) * 8;
  localparam int M_DATA_BITS = SLOT_W + ROW_W + COL_W + VALUE_W;
  localparam int M_TDATA_W = ((M_DATA_BITS + 7) / 8) * 8;
  localparam int M_TUSER_W = 2;

  localparam logic [VALUE_W-1:0] SAT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  localparam logic OP_ENTRY = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } sla_state_t;

endpackage

FILE: src/sla_div.sv
// Restoring divider computing floor(2^32 / divisor), one quotient bit per cycle.
module sla_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sla_pkg::DIST_W-1:0]  divisor,
  output logic                        done,
  output logic [sla_pkg::QUOT_W-1:0]  quotient
);
  import sla_pkg::*;

  logic                busy, busy_next;
  logic [STEP_W-1:0]   step, step_next;
  logic [DIST_W-1:0]   dvsr, dvsr_next;
  logic [DIST_W-1:0]   rem, rem_next;
  logic [QUOT_W-1:0]   quot, quot_next;
  logic                done_next;
  logic [DIST_W:0]     trial;
  logic                dividend_bit;

  // The dividend is a single one in its top bit followed by zeros.
  assign dividend_bit = (step == '0);
  assign trial        = {rem, dividend_bit};

  always_comb begin
    busy_next = busy;
    step_next = step;
    dvsr_next = dvsr;
    rem_next  = rem;
    quot_next = quot;
    done_next = 1'b0;
    if (start) begin
      busy_next = 1'b1;
      step_next = '0;
      dvsr_next = divisor;
      rem_next  = '0;
      quot_next = '0;
    end else if (busy) begin
      if (trial >= {1'b0, dvsr}) begin
        rem_next  = DIST_W'(trial - {1'b0, dvsr});
        quot_next = {quot[QUOT_W-2:0], 1'b1};
      end else begin
        rem_next  = trial[DIST_W-1:0];
        quot_next = {quot[QUOT_W-2:0], 1'b0};
      end
      step_next = step + 1'b1;
      if (step == STEP_W'(DIV_STEPS - 1)) begin
        busy_next = 1'b0;
        done_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      busy <= busy_next;
      done <= done_next;
      step <= step_next;
    end
    dvsr <= dvsr_next;
    rem  <= rem_next;
    quot <= quot_next;
  end

  assign quotient = quot;

endmodule

FILE: src/sparse_laplacian_assembler.sv
// Top level of the sparse Laplacian assembler: sequencer, column state and output register.
//
// One beat of distance data is taken when the block is idle. A kept entry with a nonzero
// distance is accepted, then waits on the restoring divider that forms the weight (33
// quotient bits at one per cycle, then its done flag is registered), and then loads the
// output register. A zero distance and a column close go from acceptance straight to the
// emit step, a dropped entry ends at acceptance. The emit step holds while the output
// register still carries a beat not yet taken; a new beat is accepted while a finished
// result waits there. Configuration writes to window_limit land at once.
module sparse_laplacian_assembler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sla_pkg::WINDOW_W-1:0]    cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // row_index [15:0], distance [47:16]
  input  logic [sla_pkg::S_TDATA_W-1:0]   s_tdata,
  // op
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // slot_index [19:0], out_row [35:20], out_column [51:36], entry_value [99:52], zero pad
  output logic [sla_pkg::M_TDATA_W-1:0]   m_tdata,
  // is_diagonal [0], saturated [1]
  output logic [sla_pkg::M_TUSER_W-1:0]   m_tuser
);
  import sla_pkg::*;

  sla_state_t          state, state_next;
  logic [WINDOW_W-1:0] window_limit, window_limit_next;
  logic [COL_W-1:0]    current_column, current_column_next;
  logic [SLOT_W-1:0]   next_slot, next_slot_next;
  logic                diagonal_reserved, diagonal_reserved_next;
  logic [SLOT_W-1:0]   diagonal_slot, diagonal_slot_next;
  logic [VALUE_W-1:0]  weight_sum, weight_sum_next;
  logic                item_op, item_op_next;
  logic [ROW_W-1:0]    item_row, item_row_next;
  logic [VALUE_W-1:0]  weight, weight_next;
  logic                weight_sat, weight_sat_next;

  logic                out_valid, out_valid_next;
  logic [SLOT_W-1:0]   out_slot, out_slot_next;
  logic [ROW_W-1:0]    out_row, out_row_next;
  logic [COL_W-1:0]    out_col, out_col_next;
  logic [VALUE_W-1:0]  out_value, out_value_next;
  logic                out_diag, out_diag_next;
  logic                out_sat, out_sat_next;

  logic                accept;
  logic                in_op;
  logic [ROW_W-1:0]    in_row;
  logic [DIST_W-1:0]   in_dist;
  logic                keep;
  logic                out_free;
  logic [SLOT_W-1:0]   slot_after;
  logic [VALUE_W-1:0]  sum_add;
  logic                div_start;
  logic                div_done;
  logic [QUOT_W-1:0]   div_quot;

  assign in_op    = s_tuser;
  assign in_row   = s_tdata[ROW_W-1:0];
  assign in_dist  = s_tdata[ROW_W +: DIST_W];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign keep     = in_dist < {window_limit, {FRAC_W{1'b0}}};
  assign out_free = !out_valid || m_tready;

  assign slot_after = (next_slot == SLOT_W'(MAX_SLOTS - 1)) ? '0 : next_slot + 1'b1;
  assign sum_add    = weight_sum + weight;

  sla_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (in_dist),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_next             = state;
    window_limit_next      = cfg_we ? cfg_wdata : window_limit;
    current_column_next    = current_column;
    next_slot_next         = next_slot;
    diagonal_reserved_next = diagonal_reserved;
    diagonal_slot_next     = diagonal_slot;
    weight_sum_next        = weight_sum;
    item_op_next           = item_op;
    item_row_next          = item_row;
    weight_next            = weight;
    weight_sat_next        = weight_sat;
    out_valid_next         = out_valid && !m_tready;
    out_slot_next          = out_slot;
    out_row_next           = out_row;
    out_col_next           = out_col;
    out_value_next         = out_value;
    out_diag_next          = out_diag;
    out_sat_next           = out_sat;
    div_start              = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          item_op_next  = in_op;
          item_row_next = in_row;
          if (in_op == OP_CLOSE) begin
            state_next = ST_EMIT;
          end else begin
            // Reserve the diagonal slot ahead of the first row below the diagonal.
            if (in_row > current_column && !diagonal_reserved) begin
              diagonal_reserved_next = 1'b1;
              diagonal_slot_next     = next_slot;
              next_slot_next         = slot_after;
            end
            if (keep) begin
              if (in_dist == '0) begin
                weight_next     = SAT_MAX;
                weight_sat_next = 1'b1;
                state_next      = ST_EMIT;
              end else begin
                div_start  = 1'b1;
                state_next = ST_DIVIDE;
              end
            end
          end
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          weight_next     = VALUE_W'(div_quot);
          weight_sat_next = 1'b0;
          state_next      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_col_next   = current_column;
          state_next     = ST_IDLE;
          if (item_op == OP_ENTRY) begin
            out_slot_next   = next_slot;
            next_slot_next  = slot_after;
            out_row_next    = item_row;
            out_value_next  = '0 - weight;
            out_diag_next   = 1'b0;
            out_sat_next    = weight_sat;
            weight_sum_next = (sum_add > SAT_MAX) ? SAT_MAX : sum_add;
          end else begin
            if (diagonal_reserved) begin
              out_slot_next = diagonal_slot;
            end else begin
              out_slot_next  = next_slot;
              next_slot_next = slot_after;
            end
            out_row_next           = current_column;
            out_value_next         = weight_sum;
            out_diag_next          = 1'b1;
            out_sat_next           = (weight_sum == SAT_MAX);
            diagonal_reserved_next = 1'b0;
            weight_sum_next        = '0;
            current_column_next    = (current_column == COL_W'(MAX_COLUMNS - 1)) ?
                                     '0 : current_column + 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      window_limit      <= WINDOW_W'(1);
      current_column    <= '0;
      next_slot         <= '0;
      diagonal_reserved <= 1'b0;
      diagonal_slot     <= '0;
      weight_sum        <= '0;
      out_valid         <= 1'b0;
    end else begin
      state             <= state_next;
      window_limit      <= window_limit_next;
      current_column    <= current_column_next;
      next_slot         <= next_slot_next;
      diagonal_reserved <= diagonal_reserved_next;
      diagonal_slot     <= diagonal_slot_next;
      weight_sum        <= weight_sum_next;
      out_valid         <= out_valid_next;
    end
    item_op    <= item_op_next;
    item_row   <= item_row_next;
    weight     <= weight_next;
    weight_sat <= weight_sat_next;
    out_slot   <= out_slot_next;
    out_row    <= out_row_next;
    out_col    <= out_col_next;
    out_value  <= out_value_next;
    out_diag   <= out_diag_next;
    out_sat    <= out_sat_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'({out_value, out_col, out_row, out_slot});
  assign m_tuser  = {out_sat, out_diag};

endmodule

FILE: src/sla_checker.sv
// Port-level checks for the sparse Laplacian assembler, bound to the top level.
module sla_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [sla_pkg::M_TDATA_W-1:0]   m_tdata,
  input logic [sla_pkg::M_TUSER_W-1:0]   m_tuser
);
  import sla_pkg::*;

  localparam int ROW_LO   = SLOT_W;
  localparam int COL_LO   = SLOT_W + ROW_W;
  localparam int VALUE_LO = SLOT_W + ROW_W + COL_W;

  // Hold a stalled beat.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      m_tdata[ROW_LO +: ROW_W] == m_tdata[COL_LO +: COL_W])
    else $error("diagonal beat with row different from column");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[VALUE_LO + VALUE_W - 1])
    else $error("off-diagonal value not negative");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      !m_tdata[VALUE_LO + VALUE_W - 1] &&
      (m_tuser[1] == (m_tdata[VALUE_LO +: VALUE_W] == SAT_MAX)))
    else $error("diagonal sum sign or saturation flag wrong");

endmodule

bind sparse_laplacian_assembler sla_checker u_sla_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: test/tb_sparse_laplacian_assembler.sv
// Self-checking testbench for the sparse Laplacian assembler stream block.
module tb_sparse_laplacian_assembler;
  timeunit 1ns;
  timeprecision 1ps;

  import sla_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 48;
  localparam int RANDOM_BEATS   = 700;
  localparam int PHASE_BEATS    = 117;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot_index;
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_column;
    logic [VALUE_W-1:0] entry_value;
    logic               is_diagonal;
    logic               saturated;
  } laplacian_entry_t;

  // Tracks column state, predicts each Laplacian entry and checks the output stream.
  class laplacian_scoreboard;
    logic [WINDOW_W-1:0] window;
    logic [COL_W-1:0]    column;
    logic [SLOT_W-1:0]   next_slot;
    logic                diag_held;
    logic [SLOT_W-1:0]   diag_slot;
    logic [VALUE_W-1:0]  weight_total;
    laplacian_entry_t    expected_entries[$];
    int unsigned         mismatches, n_entries, n_closes, n_kept, n_saturated;

    function new();
      window       = WINDOW_W'(1);
      column       = '0;
      next_slot    = '0;
      diag_held    = 1'b0;
      diag_slot    = '0;
      weight_total = '0;
    endfunction

    // Slot counter is exactly SLOT_W bits wide, so it wraps at MAX_SLOTS by itself.
    function logic [SLOT_W-1:0] claim_slot();
      logic [SLOT_W-1:0] s;
      s = next_slot;
      next_slot = next_slot + 1'b1;
      return s;
    endfunction

    function void note_beat(logic op, logic [ROW_W-1:0] row, logic [DIST_W-1:0] distance_q);
      laplacian_entry_t e;
      logic [VALUE_W-1:0] weight;
      logic [VALUE_W:0]   total;
      logic               clamped;
      if (op == OP_ENTRY) begin
        n_entries++;
        if (row > column && !diag_held) begin
          diag_held = 1'b1;
          diag_slot = claim_slot();
        end
        // Drop anything at or beyond the window; it may still have reserved the diagonal.
        if (distance_q >= {window, 16'h0000}) return;
        if (distance_q == '0) begin
          weight  = SAT_MAX;
          clamped = 1'b1;
        end else begin
          weight  = VALUE_W'((64'd1 << 32) / {32'd0, distance_q});
          clamped = 1'b0;
        end
        total = {1'b0, weight_total} + weight;
        weight_total = (total > SAT_MAX) ? SAT_MAX : total[VALUE_W-1:0];
        e.slot_index  = claim_slot();
        e.out_row     = row;
        e.out_column  = column;
        e.entry_value = '0 - weight;
        e.is_diagonal = 1'b0;
        e.saturated   = clamped;
        n_kept++;
        if (clamped) n_saturated++;
      end else begin
        n_closes++;
        if (!diag_held) diag_slot = claim_slot();
        e.slot_index  = diag_slot;
        e.out_row     = column;
        e.out_column  = column;
        e.entry_value = weight_total;
        e.is_diagonal = 1'b1;
        e.saturated   = (weight_total == SAT_MAX);
        if (e.saturated) n_saturated++;
        diag_held    = 1'b0;
        weight_total = '0;
        column       = column + 1'b1;
      end
      expected_entries.push_back(e);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_entry(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
      laplacian_entry_t want;
      if (expected_entries.size() == 0) begin
        $error("unexpected result beat: tdata 0x%0h tuser 0x%0h", data, user);
        mismatches++;
        return;
      end
      want = expected_entries.pop_front();
      compare_field("slot_index", 64'(want.slot_index), 64'(data[SLOT_W-1:0]));
      compare_field("out_row", 64'(want.out_row), 64'(data[SLOT_W +: ROW_W]));
      compare_field("out_column", 64'(want.out_column), 64'(data[SLOT_W+ROW_W +: COL_W]));
      compare_field("entry_value", 64'(want.entry_value),
                    64'(data[SLOT_W+ROW_W+COL_W +: VALUE_W]));
      compare_field("is_diagonal", 64'(want.is_diagonal), 64'(user[0]));
      compare_field("saturated", 64'(want.saturated), 64'(user[1]));
    endfunction

    function int pending();
      return expected_entries.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [WINDOW_W-1:0]   cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;

  laplacian_scoreboard sb = new();
  int unsigned burst_left = 8;
  int unsigned windows_used = 1;
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;

  sparse_laplacian_assembler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: picks a random stall mode at regular intervals and holds off for a long stretch
  // in each longer period so the block backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_entry(m_tdata, m_tuser);
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 32 == 0) rx_mode <= $urandom_range(0, 3);
      if (rx_cycle % 4096 >= 3500) begin
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0, 1:    m_tready <= 1'b1;
          2:       m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned cycles_run;
    cycles_run = 0;
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_beat(input logic op, input logic [ROW_W-1:0] row,
                           input logic [DIST_W-1:0] distance_q);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {distance_q, row};
    do @(posedge clk); while (!s_tready);
    sb.note_beat(op, row, distance_q);
  endtask

  // End the current burst now and then with a gap of random length.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
  endtask

  // Stop sending, wait for every predicted entry, then let a dropped beat finish.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WINDOW_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.window = value;
    windows_used++;
  endtask

  function automatic logic [DIST_W-1:0] pick_distance();
    logic [DIST_W-1:0] limit;
    limit = {sb.window, 16'h0000};
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return $urandom_range(1, 255);
      2, 3, 4, 5: return (limit != 0) ? $urandom_range(0, limit - 1) : $urandom;
      6, 7:       return $urandom;
      8:          return (limit != 0 && $urandom_range(0, 1)) ? limit - 1 : limit;
      default:    return $urandom_range(1, 32'h0000_FFFF);
    endcase
  endfunction

  // One column: rows mostly ascending around the diagonal, a stray row now and then,
  // and occasionally no close so entries run on into the next column.
  task automatic random_column(inout int unsigned beats);
    int unsigned n;
    int r;
    logic [ROW_W-1:0] row;
    n = $urandom_range(0, 6);
    r = int'(sb.column) - int'($urandom_range(0, 4));
    if (r < 0) r = 0;
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        row = ROW_W'($urandom);
      end else begin
        r += $urandom_range(0, 3);
        row = (r > 65535) ? 16'hFFFF : ROW_W'(r);
      end
      send_beat(OP_ENTRY, row, pick_distance());
      beats++;
      pace_sender();
    end
    if ($urandom_range(0, 19) != 0) begin
      send_beat(OP_CLOSE, ROW_W'($urandom), $urandom);
      beats++;
      pace_sender();
    end
  endtask

  initial begin
    int unsigned beats;
    logic [WINDOW_W-1:0] settings[6];
    beats = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset window of 1: zero distance, smallest distance, edge of the window,
    // a dropped high row that still reserves the diagonal.
    send_beat(OP_ENTRY, 16'h0000, 32'h0000_0000);
    send_beat(OP_ENTRY, 16'h0000, 32'h0000_0001);
    send_beat(OP_ENTRY, 16'h0000, 32'h0000_FFFF);
    send_beat(OP_ENTRY, 16'h0000, 32'h0001_0000);
    send_beat(OP_ENTRY, 16'hFFFF, 32'hFFFF_FFFF);
    send_beat(OP_CLOSE, 16'hFFFF, 32'hFFFF_FFFF);
    drain_results();

    write_window(16'hFFFF);
    send_beat(OP_ENTRY, 16'h0000, 32'hFFFE_FFFF);
    send_beat(OP_ENTRY, 16'h0002, 32'h8000_0000);
    send_beat(OP_ENTRY, 16'hFFFF, 32'h1234_5678);
    send_beat(OP_ENTRY, 16'h0003, 32'hFFFF_0000);
    send_beat(OP_CLOSE, 16'h0000, 32'h0000_0000);
    send_beat(OP_CLOSE, 16'h5A5A, 32'hA5A5_A5A5);
    send_beat(OP_ENTRY, 16'h0005, 32'h0000_0001);
    send_beat(OP_ENTRY, 16'h0001, 32'h0000_0003);
    send_beat(OP_CLOSE, 16'h0000, 32'h0000_0000);
    drain_results();

    write_window(16'h0000);
    send_beat(OP_ENTRY, 16'h0000, 32'h0000_0000);
    send_beat(OP_ENTRY, 16'h0009, 32'h0000_0001);
    send_beat(OP_CLOSE, 16'h0000, 32'h0000_0000);
    drain_results();

    settings[0] = 16'hFFFF;
    settings[1] = 16'h0000;
    settings[2] = WINDOW_W'($urandom_range(2, 16'hFFFE));
    settings[3] = 16'h0001;
    settings[4] = WINDOW_W'($urandom_range(2, 16));
    settings[5] = 16'hFFFF;
    foreach (settings[p]) begin
      write_window(settings[p]);
      while (beats < PHASE_BEATS * (p + 1) && beats < RANDOM_BEATS) random_column(beats);
      drain_results();
    end

    $display("Run covered %0d entry beats (%0d kept) and %0d column closes over %0d windows;",
             sb.n_entries, sb.n_kept, sb.n_closes, windows_used);
    $display("%0d results carried a saturated weight or sum.", sb.n_saturated);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
